// File: rtl/mhpq_pkg.sv
`default_nettype none
package mhpq_pkg;

  localparam int HEAP_CAPACITY = 64;
  localparam int ADDR_W        = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
  localparam int CNT_W         = $clog2(HEAP_CAPACITY + 1);
  // child index 2*pos+2 can reach 2*capacity
  localparam int CHILD_W       = ADDR_W + 2;
  localparam int KEY_W         = 64;
  localparam int HASH_W        = 64;
  localparam int COUNT_OUT_W   = 7;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic              pass;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_LD,
    S_DN_RD,
    S_DN_CL,
    S_DN_CR,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// File: rtl/mhpq_if.sv
`default_nettype none
interface mhpq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [mhpq_pkg::KEY_W-1:0]  key_timestamp;
  logic [mhpq_pkg::HASH_W-1:0] entry_hash;
  logic                       entry_pass;

  modport source (output valid, opcode, key_timestamp, entry_hash, entry_pass,
                  input ready);
  modport sink   (input valid, opcode, key_timestamp, entry_hash, entry_pass,
                  output ready);
endinterface

interface mhpq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [mhpq_pkg::KEY_W-1:0]        out_timestamp;
  logic [mhpq_pkg::HASH_W-1:0]       out_hash;
  logic                             out_pass;
  logic [mhpq_pkg::COUNT_OUT_W-1:0]  entry_count;

  modport source (output valid, status, out_timestamp, out_hash, out_pass, entry_count,
                  input ready);
  modport sink   (input valid, status, out_timestamp, out_hash, out_pass, entry_count,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/min_heap_priority_queue.sv
// Channel | Dir | Payload                                           | Handshake
// req     | in  | opcode, key_timestamp, entry_hash, entry_pass     | valid/ready
// rsp     | out | status, out_timestamp, out_hash, out_pass,        | valid/ready
//         |     | entry_count                                       |
//
// One item at a time, req.ready high only in idle; steps from accept to result load:
// insert: per level climbed, a parent read and a compare;
// extract: load root and tail, then per level descended a child read and a left and
//   right compare on the one comparator; full/empty: straight to the result.
// Synchronous reset empties the heap at once (fill count only); a result waiting
//   on rsp.ready stalls the block in S_RESP; each item ends back in S_IDLE.
`default_nettype none
module min_heap_priority_queue (
  input  wire           clk,
  input  wire           rst,
  mhpq_req_if.sink      req,
  mhpq_rsp_if.source    rsp
);

  mhpq_pkg::state_t state, state_next;

  // heap storage: one write port, two registered read ports
  mhpq_pkg::entry_t mem [mhpq_pkg::HEAP_CAPACITY];
  mhpq_pkg::entry_t rd_a, rd_b;
  logic                        rd_en;
  logic [mhpq_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
  logic                        wr_en;
  logic [mhpq_pkg::ADDR_W-1:0] wr_addr;
  mhpq_pkg::entry_t            wr_data;

  // sequencer registers
  logic [mhpq_pkg::CNT_W-1:0]  count, count_next;
  logic [mhpq_pkg::ADDR_W-1:0] pos, pos_next;
  mhpq_pkg::entry_t            mov, mov_next;       // entry being sifted
  logic                        left_won, left_won_next;
  mhpq_pkg::status_t           res_status, res_status_next;
  mhpq_pkg::entry_t            res_entry, res_entry_next;

  // output register
  logic                        out_valid;
  mhpq_pkg::status_t           out_status;
  mhpq_pkg::entry_t            out_entry;
  logic [mhpq_pkg::CNT_W-1:0]  out_count;

  // shared key comparator
  logic [mhpq_pkg::KEY_W-1:0]  cmp_a, cmp_b;
  logic                        cmp_lt;

  // tree index arithmetic
  logic [mhpq_pkg::ADDR_W-1:0]  parent;
  logic [mhpq_pkg::CHILD_W-1:0] lc, rc, cnt_ext;
  logic                         lc_ok, rc_ok;
  logic                         accept, full, empty, out_load;

  assign parent  = (pos - mhpq_pkg::ADDR_W'(1)) >> 1;
  assign lc      = mhpq_pkg::CHILD_W'({pos, 1'b1});
  assign rc      = lc + mhpq_pkg::CHILD_W'(1);
  assign cnt_ext = mhpq_pkg::CHILD_W'(count);
  assign lc_ok   = lc < cnt_ext;
  assign rc_ok   = rc < cnt_ext;

  assign full   = count == mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_CAPACITY);
  assign empty  = count == '0;
  assign accept = req.valid && req.ready;
  assign req.ready = (state == mhpq_pkg::S_IDLE);
  assign out_load  = !out_valid || rsp.ready;

  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    unique case (state)
      mhpq_pkg::S_UP_CMP: begin
        cmp_a = mov.key;
        cmp_b = rd_a.key;
      end
      mhpq_pkg::S_DN_CL: begin
        cmp_a = rd_a.key;
        cmp_b = mov.key;
      end
      mhpq_pkg::S_DN_CR: begin
        cmp_a = rd_b.key;
        cmp_b = left_won ? rd_a.key : mov.key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mhpq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == mhpq_pkg::S_RESP && out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    mov        <= mov_next;
    left_won   <= left_won_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    if (state == mhpq_pkg::S_RESP && out_load) begin
      out_status <= res_status;
      out_entry  <= res_entry;
      out_count  <= count;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    mov_next        = mov;
    left_won_next   = left_won;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    rd_en           = 1'b0;
    rd_addr_a       = '0;
    rd_addr_b       = '0;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = mov;

    unique case (state)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          res_status_next = mhpq_pkg::ST_OK;
          res_entry_next  = '0;
          if (req.opcode == mhpq_pkg::OP_INSERT) begin
            if (full) begin
              res_status_next = mhpq_pkg::ST_FULL;
              state_next      = mhpq_pkg::S_RESP;
            end else begin
              mov_next.key  = req.key_timestamp;
              mov_next.hash = req.entry_hash;
              mov_next.pass = req.entry_pass;
              pos_next      = mhpq_pkg::ADDR_W'(count);
              count_next    = count + mhpq_pkg::CNT_W'(1);
              state_next    = mhpq_pkg::S_UP_RD;
            end
          end else begin
            if (empty) begin
              res_status_next = mhpq_pkg::ST_EMPTY;
              state_next      = mhpq_pkg::S_RESP;
            end else begin
              // fetch root and tail together
              rd_en      = 1'b1;
              rd_addr_a  = '0;
              rd_addr_b  = mhpq_pkg::ADDR_W'(count - mhpq_pkg::CNT_W'(1));
              state_next = mhpq_pkg::S_EX_LD;
            end
          end
        end
      end

      mhpq_pkg::S_UP_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          state_next = mhpq_pkg::S_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_addr_a  = parent;
          state_next = mhpq_pkg::S_UP_CMP;
        end
      end

      mhpq_pkg::S_UP_CMP: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          // parent moves down, keep climbing
          wr_data    = rd_a;
          pos_next   = parent;
          state_next = mhpq_pkg::S_UP_RD;
        end else begin
          state_next = mhpq_pkg::S_RESP;
        end
      end

      mhpq_pkg::S_EX_LD: begin
        res_entry_next = rd_a;
        mov_next       = rd_b;
        pos_next       = '0;
        count_next     = count - mhpq_pkg::CNT_W'(1);
        state_next     = mhpq_pkg::S_DN_RD;
      end

      mhpq_pkg::S_DN_RD: begin
        if (!lc_ok) begin
          // leaf: settle here
          wr_en      = 1'b1;
          state_next = mhpq_pkg::S_RESP;
        end else begin
          rd_en      = 1'b1;
          rd_addr_a  = lc[mhpq_pkg::ADDR_W-1:0];
          rd_addr_b  = rc[mhpq_pkg::ADDR_W-1:0];
          state_next = mhpq_pkg::S_DN_CL;
        end
      end

      mhpq_pkg::S_DN_CL: begin
        left_won_next = cmp_lt;
        state_next    = mhpq_pkg::S_DN_CR;
      end

      mhpq_pkg::S_DN_CR: begin
        wr_en = 1'b1;
        if (rc_ok && cmp_lt) begin
          wr_data    = rd_b;
          pos_next   = rc[mhpq_pkg::ADDR_W-1:0];
          state_next = mhpq_pkg::S_DN_RD;
        end else if (left_won) begin
          wr_data    = rd_a;
          pos_next   = lc[mhpq_pkg::ADDR_W-1:0];
          state_next = mhpq_pkg::S_DN_RD;
        end else begin
          state_next = mhpq_pkg::S_RESP;
        end
      end

      mhpq_pkg::S_RESP: begin
        if (out_load) begin
          state_next = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.out_timestamp = out_entry.key;
  assign rsp.out_hash      = out_entry.hash;
  assign rsp.out_pass      = out_entry.pass;
  assign rsp.entry_count   = mhpq_pkg::COUNT_OUT_W'(out_count);

endmodule
`default_nettype wire

// File: rtl/mhpq_checker.sv
`default_nettype none
module mhpq_checker (
  input wire                              clk,
  input wire                              rst,
  input wire                              rsp_valid,
  input wire                              rsp_ready,
  input wire [1:0]                        rsp_status,
  input wire [mhpq_pkg::KEY_W-1:0]        rsp_out_timestamp,
  input wire [mhpq_pkg::HASH_W-1:0]       rsp_out_hash,
  input wire                              rsp_out_pass,
  input wire [mhpq_pkg::COUNT_OUT_W-1:0]  rsp_entry_count
);

  localparam logic [mhpq_pkg::COUNT_OUT_W-1:0] CAP_SHOWN =
    mhpq_pkg::COUNT_OUT_W'(mhpq_pkg::HEAP_CAPACITY);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_out_timestamp) && $stable(rsp_out_hash)
      && $stable(rsp_entry_count))
    else $error("rsp changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  // rejected insert reports a full heap
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mhpq_pkg::ST_FULL |-> rsp_entry_count == CAP_SHOWN)
    else $error("full status with wrong count");

  // empty extract reports zero entries
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mhpq_pkg::ST_EMPTY |-> rsp_entry_count == '0)
    else $error("empty status with nonzero count");

  // failed insert or extract returns no entry data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != mhpq_pkg::ST_OK
      |-> rsp_out_timestamp == '0 && rsp_out_hash == '0 && !rsp_out_pass)
    else $error("entry data on failed operation");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_out_timestamp (rsp.out_timestamp),
  .rsp_out_hash      (rsp.out_hash),
  .rsp_out_pass      (rsp.out_pass),
  .rsp_entry_count   (rsp.entry_count)
);
`default_nettype wire
